[rtl/a2t_pkg.sv]
// shared widths, constants and types for the atan2 turns unit
package a2t_pkg;

  localparam int COMP_W  = 32;            // signed 16.16 input component
  localparam int MAG_W   = 32;            // magnitude, holds 2^31
  localparam int REM_W   = MAG_W + 1;     // divider partial remainder
  localparam int RATIO_W = 17;            // ratio 0..0x10000
  localparam int FRAC_W  = 16;            // fraction bits of 16.16
  localparam int DIV_STEPS = RATIO_W;     // one quotient bit per stage
  localparam int CORR_W  = 12;
  localparam int M1_W    = 12;            // corr * (1 - r), at most 0x0B20
  localparam int SUM_W   = 14;            // base + m1, at most 0x2B20
  localparam int OCT_W   = 14;            // octant angle, at most 0x2000
  localparam int ANGLE_W = 16;

  localparam logic [ANGLE_W-1:0] ZERO_ANGLE   = 16'hC000;
  localparam logic [SUM_W-1:0]   POLY_BASE    = 14'h2000;
  localparam logic [CORR_W-1:0]  POLY_CORR    = 12'hB20;
  localparam logic [RATIO_W-1:0] FIX_ONE      = 17'h10000;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'h8000;

  // octant fold decisions, carried down the pipe with each vector
  typedef struct packed {
    logic zero;
    logic swap;
    logic mirror;
    logic negate;
  } fold_flags_t;

endpackage

[rtl/a2t_vec_if.sv]
// input stream channel: vector components
interface a2t_vec_if;
  import a2t_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] vec_x;
  logic signed [COMP_W-1:0] vec_y;

  modport source (output valid, output vec_x, output vec_y, input ready);
  modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

[rtl/a2t_angle_if.sv]
// output stream channel: angle in turns
interface a2t_angle_if;
  import a2t_pkg::*;

  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

[rtl/a2t_fold.sv]
// first stage: magnitudes and octant fold of the input vector
module a2t_fold (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [a2t_pkg::COMP_W-1:0] vec_x,
  input  logic signed [a2t_pkg::COMP_W-1:0] vec_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output a2t_pkg::fold_flags_t              out_flags,
  output logic [a2t_pkg::MAG_W-1:0]         out_lo,
  output logic [a2t_pkg::MAG_W-1:0]         out_hi
);
  import a2t_pkg::*;

  logic              en;
  logic [MAG_W-1:0]  ax;
  logic [MAG_W-1:0]  ay;
  fold_flags_t       flags_next;

  // magnitudes; the most negative code gives 2^31 exactly
  assign ax = vec_x[COMP_W-1] ? MAG_W'(~vec_x + 1'b1) : MAG_W'(vec_x);
  assign ay = vec_y[COMP_W-1] ? MAG_W'(~vec_y + 1'b1) : MAG_W'(vec_y);

  // fold decisions; screen y down means math y is negative when vec_y > 0
  always_comb begin
    flags_next.zero   = (vec_x == '0) && (vec_y == '0);
    flags_next.mirror = vec_x[COMP_W-1];
    flags_next.negate = (vec_y != '0) && !vec_y[COMP_W-1];
    flags_next.swap   = ay > ax;
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flags <= flags_next;
      out_lo    <= flags_next.swap ? ax : ay;
      out_hi    <= flags_next.swap ? ay : ax;
    end
  end

  // the fold always leaves the smaller magnitude as dividend
  a_lo_le_hi: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_lo <= out_hi))
    else $error("fold left lo above hi");

endmodule

[rtl/a2t_div.sv]
// pipelined restoring divider: r = (lo << 16) / hi, one quotient bit per stage
module a2t_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  a2t_pkg::fold_flags_t        in_flags,
  input  logic [a2t_pkg::MAG_W-1:0]   in_lo,
  input  logic [a2t_pkg::MAG_W-1:0]   in_hi,
  output logic                        out_valid,
  input  logic                        out_ready,
  output a2t_pkg::fold_flags_t        out_flags,
  output logic [a2t_pkg::RATIO_W-1:0] out_ratio
);
  import a2t_pkg::*;

  localparam int LAST = DIV_STEPS - 1;

  logic                v     [DIV_STEPS];
  logic                en    [DIV_STEPS];
  logic [REM_W-1:0]    rem   [DIV_STEPS];
  logic [MAG_W-1:0]    hi    [DIV_STEPS];
  logic [RATIO_W-1:0]  quo   [DIV_STEPS];
  fold_flags_t         flags [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic             up_valid;
    logic [REM_W-1:0] rem_in;
    logic [MAG_W-1:0] hi_in;
    logic [RATIO_W-1:0] quo_prev;
    fold_flags_t      flags_in;
    logic             qbit;
    logic [REM_W-1:0] rem_next;
    logic [RATIO_W-1:0] quo_next;

    // upstream of this stage; later stages shift in a zero dividend bit
    if (k == 0) begin : g_first
      assign up_valid = in_valid;
      assign rem_in   = {1'b0, in_lo};
      assign hi_in    = in_hi;
      assign quo_prev = '0;
      assign flags_in = in_flags;
    end else begin : g_rest
      assign up_valid = v[k-1];
      assign rem_in   = {rem[k-1][REM_W-2:0], 1'b0};
      assign hi_in    = hi[k-1];
      assign quo_prev = quo[k-1];
      assign flags_in = flags[k-1];
    end

    // stage advances when empty or when the next one moves
    if (k == LAST) begin : g_en_last
      assign en[k] = !v[k] || out_ready;
    end else begin : g_en_mid
      assign en[k] = !v[k] || en[k+1];
    end

    // trial subtract
    assign qbit     = rem_in >= {1'b0, hi_in};
    assign rem_next = qbit ? (rem_in - {1'b0, hi_in}) : rem_in;
    assign quo_next = {quo_prev[RATIO_W-2:0], qbit};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= up_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]   <= rem_next;
        hi[k]    <= hi_in;
        quo[k]   <= quo_next;
        flags[k] <= flags_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[LAST];
  assign out_flags = flags[LAST];
  assign out_ratio = quo[LAST];

  // remainder stays below the divisor for any nonzero vector
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (v[LAST] && !flags[LAST].zero) |-> (rem[LAST] < {1'b0, hi[LAST]}))
    else $error("divider remainder not below divisor");

  // ratio of min over max never exceeds one
  a_ratio_max: assert property (@(posedge clk) disable iff (rst)
    (v[LAST] && !flags[LAST].zero) |-> (quo[LAST] <= FIX_ONE))
    else $error("ratio above one");

endmodule

[rtl/a2t_poly.sv]
// polynomial octant angle and unfold to a full-turn angle
module a2t_poly (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  a2t_pkg::fold_flags_t        in_flags,
  input  logic [a2t_pkg::RATIO_W-1:0] in_ratio,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [a2t_pkg::ANGLE_W-1:0] out_angle
);
  import a2t_pkg::*;

  localparam int P1_W = CORR_W + RATIO_W;
  localparam int P2_W = RATIO_W + SUM_W;

  logic               va, vb;
  logic               en_a, en_b, en_c;
  fold_flags_t        flags_a, flags_b;
  logic [RATIO_W-1:0] ratio_a;
  logic [M1_W-1:0]    m1_a;
  logic [OCT_W-1:0]   oct_b;

  logic [RATIO_W-1:0] one_minus;
  logic [P1_W-1:0]    prod1;
  logic [SUM_W-1:0]   sum;
  logic [P2_W-1:0]    prod2;
  logic [ANGLE_W-1:0] res_swap, res_mirror, res_negate;
  logic [ANGLE_W-1:0] angle_next;

  assign en_c     = !out_valid || out_ready;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  // stage a: corr * (1 - r)
  assign one_minus = FIX_ONE - in_ratio;
  assign prod1     = P1_W'(POLY_CORR) * P1_W'(one_minus);

  // stage b: r * (base + m1)
  assign sum   = POLY_BASE + SUM_W'(m1_a);
  assign prod2 = P2_W'(ratio_a) * P2_W'(sum);

  // stage c: undo swap, then mirror, then negate, modulo one turn
  always_comb begin
    res_swap   = flags_b.swap ? (QUARTER_TURN - ANGLE_W'(oct_b)) : ANGLE_W'(oct_b);
    res_mirror = flags_b.mirror ? (HALF_TURN - res_swap) : res_swap;
    res_negate = flags_b.negate ? (ANGLE_W'(0) - res_mirror) : res_mirror;
    angle_next = flags_b.zero ? ZERO_ANGLE : res_negate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      flags_a <= in_flags;
      ratio_a <= in_ratio;
      m1_a    <= prod1[FRAC_W +: M1_W];
    end
    if (en_b) begin
      flags_b <= flags_a;
      oct_b   <= prod2[FRAC_W +: OCT_W];
    end
    if (en_c) begin
      out_angle <= angle_next;
    end
  end

  // octant angle never passes one eighth of a turn
  a_oct_max: assert property (@(posedge clk) disable iff (rst)
    (vb && !flags_b.zero) |-> (oct_b <= OCT_W'(POLY_BASE)))
    else $error("octant angle above eighth turn");

endmodule

[rtl/fixed_point_atan2_turns_unit.sv]
// top level of the atan2 turns unit: fold, divider and polynomial pipeline
//
//   channel    | dir | payload                     | transfer when
//   vec_in     | in  | vec_x, vec_y (s16.16)       | vec_in.valid && vec_in.ready
//   angle_out  | out | angle (u16, 65536 = 1 turn) | angle_out.valid && angle_out.ready
//
// one vector per cycle sustained while angle_out is ready
// the divider resolves one quotient bit per stage
// rst is synchronous and clears only the stage valid bits
// each stage holds while the one after it is full and stalled, so bubbles
// close up and a new vector is taken while a result waits at the output
module fixed_point_atan2_turns_unit (
  input  logic        clk,
  input  logic        rst,
  a2t_vec_if.sink     vec_in,
  a2t_angle_if.source angle_out
);
  import a2t_pkg::*;

  logic               fold_valid, fold_ready;
  fold_flags_t        fold_flags;
  logic [MAG_W-1:0]   fold_lo, fold_hi;
  logic               div_valid, div_ready;
  fold_flags_t        div_flags;
  logic [RATIO_W-1:0] div_ratio;

  a2t_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec_in.valid),
    .in_ready  (vec_in.ready),
    .vec_x     (vec_in.vec_x),
    .vec_y     (vec_in.vec_y),
    .out_valid (fold_valid),
    .out_ready (fold_ready),
    .out_flags (fold_flags),
    .out_lo    (fold_lo),
    .out_hi    (fold_hi)
  );

  a2t_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fold_valid),
    .in_ready  (fold_ready),
    .in_flags  (fold_flags),
    .in_lo     (fold_lo),
    .in_hi     (fold_hi),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_flags (div_flags),
    .out_ratio (div_ratio)
  );

  a2t_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_flags  (div_flags),
    .in_ratio  (div_ratio),
    .out_valid (angle_out.valid),
    .out_ready (angle_out.ready),
    .out_angle (angle_out.angle)
  );

endmodule

[tb/sv/fixed_point_atan2_turns_unit_tb.sv]
// testbench for the atan2 turns unit: random and corner vectors, angles checked in order
`timescale 1ns / 1ps

module fixed_point_atan2_turns_unit_tb;
  import a2t_pkg::*;

  localparam int RANDOM_PER_PHASE = 600;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 40;     // pipeline latency plus margin
  localparam int MAX_PRINTED      = 20;
  localparam logic signed [COMP_W-1:0] MAX_COMP = 32'sh7FFF_FFFF;
  localparam logic signed [COMP_W-1:0] MIN_COMP = 32'sh8000_0000;

  // one vector in flight and the angle it should produce
  typedef struct {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic [ANGLE_W-1:0]       angle;
  } angle_expect_t;

  // fold into the first octant, polynomial on the ratio, then unfold
  function automatic logic [ANGLE_W-1:0] expected_angle(input logic signed [COMP_W-1:0] x,
                                                        input logic signed [COMP_W-1:0] y);
    logic [MAG_W-1:0]   ax, ay, lo, hi;
    logic [47:0]        num;
    logic [RATIO_W-1:0] ratio;
    logic [63:0]        corr, oct;
    logic [ANGLE_W-1:0] res;
    logic               do_swap, do_mirror, do_negate;
    if (x == 0 && y == 0) return ZERO_ANGLE;
    // screen y points down, so a positive y is a negative math-space y
    do_mirror = x[COMP_W-1];
    do_negate = (y != 0) && !y[COMP_W-1];
    ax = x[COMP_W-1] ? MAG_W'(-x) : MAG_W'(x);
    ay = y[COMP_W-1] ? MAG_W'(-y) : MAG_W'(y);
    do_swap = ay > ax;
    lo = do_swap ? ax : ay;
    hi = do_swap ? ay : ax;
    num = {lo, 16'h0000};
    ratio = RATIO_W'(num / {16'h0000, hi});
    corr = (64'(POLY_CORR) * (64'(FIX_ONE) - 64'(ratio))) >> FRAC_W;
    oct = (64'(ratio) * (64'(POLY_BASE) + corr)) >> FRAC_W;
    res = ANGLE_W'(oct);
    // unfold: swap, mirror, negate, all modulo 2^16
    if (do_swap) res = QUARTER_TURN - res;
    if (do_mirror) res = HALF_TURN - res;
    if (do_negate) res = -res;
    return res;
  endfunction

  // in-order store of predicted angles
  class angle_scoreboard;
    angle_expect_t pending_angles[$];
    int unsigned   mismatches;
    int unsigned   vectors_seen;
    int unsigned   angles_checked;
    int unsigned   zero_vectors;
    int unsigned   extreme_vectors;

    function void note_vector(input logic signed [COMP_W-1:0] x,
                              input logic signed [COMP_W-1:0] y);
      angle_expect_t e;
      e.x = x;
      e.y = y;
      e.angle = expected_angle(x, y);
      pending_angles.push_back(e);
      vectors_seen++;
      if (x == 0 && y == 0) zero_vectors++;
      if (x == MIN_COMP || y == MIN_COMP) extreme_vectors++;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_angle(input logic [ANGLE_W-1:0] got);
      angle_expect_t e;
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("angle %h with no vector outstanding", got));
      end else begin
        e = pending_angles.pop_front();
        angles_checked++;
        if (got !== e.angle)
          report_mismatch($sformatf("x=%h y=%h angle %h, expected %h",
                                    e.x, e.y, got, e.angle));
      end
    endtask

    function int pending_count();
      return pending_angles.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  a2t_vec_if   vec_ch ();
  a2t_angle_if ang_ch ();

  fixed_point_atan2_turns_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .vec_in    (vec_ch),
    .angle_out (ang_ch)
  );

  angle_scoreboard scoreboard = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          long_hold_req;
  int unsigned hold_left;
  int unsigned held_cycles;
  int unsigned input_stall_cycles;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // output side: random ready, plus one long hold-off when asked
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left = LONG_HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      held_cycles++;
      ang_ch.ready <= 1'b0;
    end else begin
      ang_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check each angle transfer, and watch for input backpressure
  always @(posedge clk) begin
    if (!rst) begin
      if (ang_ch.valid && ang_ch.ready) scoreboard.check_angle(ang_ch.angle);
      if (vec_ch.valid && !vec_ch.ready) input_stall_cycles++;
    end
  end

  // offer one vector, with random idle cycles first; entered and left at a falling edge
  task automatic send_vector(input logic signed [COMP_W-1:0] x,
                             input logic signed [COMP_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      vec_ch.valid <= 1'b0;
      @(negedge clk);
    end
    vec_ch.valid <= 1'b1;
    vec_ch.vec_x <= x;
    vec_ch.vec_y <= y;
    @(posedge clk);
    while (!vec_ch.ready) @(posedge clk);
    scoreboard.note_vector(x, y);
    @(negedge clk);
  endtask

  function automatic logic signed [COMP_W-1:0] with_sign(input logic [MAG_W-1:0] mag);
    return $urandom_range(1) ? -$signed(mag) : $signed(mag);
  endfunction

  // random vector drawn from a few shapes
  function automatic void pick_vector(output logic signed [COMP_W-1:0] x,
                                      output logic signed [COMP_W-1:0] y);
    logic [MAG_W-1:0] m;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        x = $urandom;
        y = $urandom;
      end
      4: begin
        x = with_sign($urandom_range(32'h3_FFFF));
        y = with_sign($urandom_range(32'h3_FFFF));
      end
      5: begin
        // near the diagonal, where the swap decision flips
        m = $urandom >> $urandom_range(1, 31);
        x = with_sign(m);
        y = with_sign(m + $urandom_range(4) - 2);
        if ($urandom_range(1)) {x, y} = {y, x};
      end
      6: begin
        // on or close to an axis
        x = with_sign($urandom >> $urandom_range(1, 31));
        y = with_sign($urandom_range(2));
        if ($urandom_range(1)) {x, y} = {y, x};
      end
      7: begin
        x = with_sign(32'h7FFF_FFFF - $urandom_range(255));
        y = with_sign(32'h7FFF_FFFF - $urandom_range(255));
      end
      8: begin
        x = with_sign($urandom >> $urandom_range(1, 31));
        y = with_sign($urandom >> $urandom_range(1, 31));
      end
      default: begin
        x = ($urandom_range(3) == 0) ? MIN_COMP : with_sign($urandom_range(3));
        y = with_sign($urandom_range(3));
      end
    endcase
  endfunction

  // stimulus
  initial begin
    logic signed [COMP_W-1:0] rx, ry;
    int unsigned send_pct[3];
    int unsigned recv_pct[3];
    send_pct = '{20, 62, 0};
    recv_pct = '{62, 20, 0};
    rst = 1'b1;
    vec_ch.valid = 1'b0;
    vec_ch.vec_x = '0;
    vec_ch.vec_y = '0;
    ang_ch.ready = 1'b0;
    long_hold_req = 1'b0;
    hold_left = 0;
    held_cycles = 0;
    input_stall_cycles = 0;
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corners: zero, axes, extremes, diagonals, most negative component
    send_vector(0, 0);
    send_vector(1, 0);
    send_vector(-1, 0);
    send_vector(0, 1);
    send_vector(0, -1);
    send_vector(MAX_COMP, 0);
    send_vector(-MAX_COMP, 0);
    send_vector(0, MAX_COMP);
    send_vector(0, -MAX_COMP);
    send_vector(MAX_COMP, MAX_COMP);
    send_vector(-MAX_COMP, MAX_COMP);
    send_vector(MAX_COMP, -MAX_COMP);
    send_vector(-MAX_COMP, -MAX_COMP);
    send_vector(1, MAX_COMP);
    send_vector(MAX_COMP, -1);
    send_vector(1, 1);
    send_vector(-1, -1);
    send_vector(32'sh0001_0000, 32'sh0000_FFFF);
    send_vector(-32'sh0001_0000, 32'sh0001_0001);
    send_vector(MIN_COMP, 0);
    send_vector(0, MIN_COMP);
    send_vector(MIN_COMP, MIN_COMP);
    send_vector(MIN_COMP, MAX_COMP);
    send_vector(MAX_COMP, MIN_COMP);

    // random phases with different idle patterns
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      if (p == 2) long_hold_req = 1'b1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        pick_vector(rx, ry);
        send_vector(rx, ry);
      end
    end
    vec_ch.valid <= 1'b0;

    // drain
    while (scoreboard.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d vectors sent, %0d angles checked, %0d zero vectors, %0d with -2^31",
             scoreboard.vectors_seen, scoreboard.angles_checked,
             scoreboard.zero_vectors, scoreboard.extreme_vectors);
    $display("run: output held off %0d cycles, input stalled %0d cycles, %0d mismatches",
             held_cycles, input_stall_cycles, scoreboard.mismatches);
    if (scoreboard.mismatches == 0 && scoreboard.pending_count() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("timeout with %0d angles outstanding", scoreboard.pending_count());
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/a2t_pkg.sv
rtl/a2t_vec_if.sv
rtl/a2t_angle_if.sv
rtl/a2t_fold.sv
rtl/a2t_div.sv
rtl/a2t_poly.sv
rtl/fixed_point_atan2_turns_unit.sv
tb/sv/fixed_point_atan2_turns_unit_tb.sv
